@@ src/packet_blocklist_rate_limiter_top_assert.svh @@
// Assertion macros shared by the rate limiter RTL.
// Every macro samples on clk and is switched off while arst_n is low.
`ifndef PACKET_BLOCKLIST_RATE_LIMITER_TOP_ASSERT_SVH
`define PACKET_BLOCKLIST_RATE_LIMITER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pbrl_pkg.sv @@
`default_nettype none

package pbrl_pkg;

	// Flow table geometry.
	localparam int BUCKET_BITS = 8;
	localparam int WAYS        = 4;
	localparam int NBUCKETS    = 1 << BUCKET_BITS;
	localparam int ENTRIES     = NBUCKETS * WAYS;
	localparam int IDX_BITS    = $clog2(ENTRIES);
	localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam logic [31:0] HASH_MUL  = 32'h61C8_8647;
	localparam logic [16:0] COUNT_MAX = 17'h1_FFFF;
	localparam logic [7:0]  PROTO_TCP = 8'd6;

	// Configuration reset values.
	localparam logic [30:0] WINDOW_MS_RST = 31'd60000;
	localparam logic [15:0] MAX_CONNS_RST = 16'd100;
	localparam logic [31:0] BLOCKED_A_RST = 32'hC0A8_0001;
	localparam logic [31:0] BLOCKED_B_RST = 32'h0A00_020F;
	localparam logic [31:0] BLOCKED_C_RST = 32'h0A00_0002;
	localparam logic [31:0] BLOCKED_D_RST = 32'h0000_0000;
	localparam logic [31:0] BLOCKED_E_RST = 32'h0000_0000;

	localparam int CFG_IDX_BITS = 3;
	localparam int NBLOCKED     = 5;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW_MS = 3'd0,
		REG_MAX_CONNS = 3'd1,
		REG_BLOCKED_A = 3'd2,
		REG_BLOCKED_B = 3'd3,
		REG_BLOCKED_C = 3'd4,
		REG_BLOCKED_D = 3'd5,
		REG_BLOCKED_E = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT  = 2'd0,
		VERDICT_BLOCKED = 2'd1,
		VERDICT_RATE    = 2'd2,
		VERDICT_FULL    = 2'd3
	} verdict_t;

	typedef struct packed {
		logic        header_present;
		logic [7:0]  protocol;
		logic [31:0] source_addr;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		verdict_t verdict;
		logic     first_over_limit;
	} out_t;

	// One flow table entry as stored in the table RAM.
	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [16:0] count;
		logic [31:0] start;
		logic        noted;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [IDX_BITS-1:0] entry_index(
		input logic [BUCKET_BITS-1:0] bucket,
		input logic [WAY_BITS-1:0]    way
	);
		logic [IDX_BITS+WAY_BITS:0] full;
		full = (IDX_BITS+WAY_BITS+1)'(bucket) * (IDX_BITS+WAY_BITS+1)'(WAYS)
			+ (IDX_BITS+WAY_BITS+1)'(way);
		return full[IDX_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/pbrl_ram.sv @@
`default_nettype none

module pbrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ src/packet_blocklist_rate_limiter_top.sv @@
// Channel   Direction  Beat payload / fields
// in        sink       in_t: header_present, protocol, source_addr, now_ms
// out       source     out_t: verdict, first_over_limit
// cfg       sink       write only: cfg_wr_en, cfg_index, cfg_wr_data
//
// One input beat is worked at a time; in_ready is high only while the sequencer waits.
// A non-TCP or blocked beat goes from ST_HASH straight to ST_DONE; an insert or a hit walks the ways,
// a hit then passes ST_TIME and ST_COUNT, and a full bucket reads every way (one RAM read per way).
// After reset a clearing pass writes all ENTRIES (1024) table entries invalid.
// A stalled out beat waits in the output register while the next in beat is taken.
`default_nettype none
`include "packet_blocklist_rate_limiter_top_assert.svh"

module packet_blocklist_rate_limiter_top
	import pbrl_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire in_t                     in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output out_t                         out_data,
	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [31:0]             cfg_wr_data
);

	// Configuration registers. An index with no register behind it is ignored.
	logic [30:0] window_q;
	logic [15:0] max_q;
	logic [31:0] blocked_q [NBLOCKED];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_MS_RST;
			max_q        <= MAX_CONNS_RST;
			blocked_q[0] <= BLOCKED_A_RST;
			blocked_q[1] <= BLOCKED_B_RST;
			blocked_q[2] <= BLOCKED_C_RST;
			blocked_q[3] <= BLOCKED_D_RST;
			blocked_q[4] <= BLOCKED_E_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW_MS: window_q     <= cfg_wr_data[30:0];
				REG_MAX_CONNS: max_q        <= cfg_wr_data[15:0];
				REG_BLOCKED_A: blocked_q[0] <= cfg_wr_data;
				REG_BLOCKED_B: blocked_q[1] <= cfg_wr_data;
				REG_BLOCKED_C: blocked_q[2] <= cfg_wr_data;
				REG_BLOCKED_D: blocked_q[3] <= cfg_wr_data;
				REG_BLOCKED_E: blocked_q[4] <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_MATCH,
		ST_TIME,
		ST_COUNT,
		ST_DONE
	} state_t;

	state_t                 state_q;
	in_t                    item_q;
	logic [BUCKET_BITS-1:0] bucket_q;
	logic [WAY_BITS-1:0]    way_q;
	logic [IDX_BITS-1:0]    clr_q;
	logic [IDX_BITS-1:0]    hit_idx_q;
	entry_t                 ent_q;
	logic                   expired_q;
	logic [16:0]            cnt_q;
	verdict_t               verdict_q;
	logic                   first_q;
	out_t                   out_q;
	logic                   out_valid_q;

	// The table RAM holds the valid bit of each entry next to its fields, which is
	// why it needs the clearing pass after reset.
	logic                ram_wr_en;
	logic [IDX_BITS-1:0] ram_wr_addr;
	entry_t              ram_wr_data;
	logic                ram_rd_en;
	logic [IDX_BITS-1:0] ram_rd_addr;
	logic [ENTRY_W-1:0]  ram_rd_bits;
	entry_t              rd_ent;

	pbrl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_bits)
	);

	assign rd_ent = entry_t'(ram_rd_bits);

	// Hash multiplier; its result is registered into bucket_q before any use.
	logic [31:0] hash_prod;
	assign hash_prod = item_q.source_addr * HASH_MUL;

	logic blocked_hit;
	always_comb begin
		blocked_hit = 1'b0;
		for (int i = 0; i < NBLOCKED; i++) begin
			if (blocked_q[i] == item_q.source_addr) begin
				blocked_hit = 1'b1;
			end
		end
	end

	logic [IDX_BITS-1:0] cur_idx;
	assign cur_idx = entry_index(bucket_q, way_q);

	// One shared magnitude comparator. The window test uses it in ST_TIME and the
	// limit test in ST_COUNT.
	logic [31:0] elapsed;
	logic [31:0] gt_a;
	logic [31:0] gt_b;
	logic        gt;
	logic [16:0] cnt_inc;

	assign elapsed = item_q.now_ms - ent_q.start;
	assign cnt_inc = (ent_q.count < COUNT_MAX) ? ent_q.count + 17'd1 : ent_q.count;

	always_comb begin
		unique case (state_q)
			ST_TIME: begin
				gt_a = elapsed;
				gt_b = {1'b0, window_q};
			end
			ST_COUNT: begin
				gt_a = {15'd0, cnt_q};
				gt_b = {16'd0, max_q};
			end
			default: begin
				gt_a = '0;
				gt_b = '0;
			end
		endcase
	end

	assign gt = gt_a > gt_b;

	// A fresh entry as written on insert or on a new window.
	entry_t fresh_ent;
	always_comb begin
		fresh_ent       = '0;
		fresh_ent.valid = 1'b1;
		fresh_ent.addr  = item_q.source_addr;
		fresh_ent.count = 17'd1;
		fresh_ent.start = item_q.now_ms;
		fresh_ent.noted = 1'b0;
	end

	// Table write port: clearing pass, insert into the first free way, or write-back
	// of a hit entry.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = cur_idx;
		ram_wr_data = fresh_ent;
		ram_rd_en   = (state_q == ST_READ);
		ram_rd_addr = cur_idx;
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
				ram_wr_data = '0;
			end
			ST_MATCH: begin
				ram_wr_en = !rd_ent.valid;
			end
			ST_COUNT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = hit_idx_q;
				if (!expired_q) begin
					ram_wr_data       = ent_q;
					ram_wr_data.count = cnt_q;
					ram_wr_data.noted = ent_q.noted | gt;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Sequencer. Ways are filled from the lowest one up and never freed, so the valid
	// ways of a bucket form an unbroken run from way zero. The walk thus stops at the
	// first invalid way, which is also the lowest free one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			item_q      <= '0;
			bucket_q    <= '0;
			way_q       <= '0;
			hit_idx_q   <= '0;
			ent_q       <= '0;
			expired_q   <= 1'b0;
			cnt_q       <= '0;
			verdict_q   <= VERDICT_ACCEPT;
			first_q     <= 1'b0;
		end else begin
			// In ST_DONE the output register is handled by that state alone.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_BITS'(1);
					if (clr_q == IDX_BITS'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					bucket_q  <= hash_prod[31 -: BUCKET_BITS];
					way_q     <= '0;
					first_q   <= 1'b0;
					verdict_q <= VERDICT_ACCEPT;
					if (!item_q.header_present || item_q.protocol != PROTO_TCP) begin
						state_q <= ST_DONE;
					end else if (blocked_hit) begin
						verdict_q <= VERDICT_BLOCKED;
						state_q   <= ST_DONE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					if (!rd_ent.valid) begin
						state_q <= ST_DONE;
					end else if (rd_ent.addr == item_q.source_addr) begin
						ent_q     <= rd_ent;
						hit_idx_q <= cur_idx;
						state_q   <= ST_TIME;
					end else if (way_q == WAY_BITS'(WAYS - 1)) begin
						verdict_q <= VERDICT_FULL;
						state_q   <= ST_DONE;
					end else begin
						way_q   <= way_q + WAY_BITS'(1);
						state_q <= ST_READ;
					end
				end
				ST_TIME: begin
					expired_q <= gt;
					cnt_q     <= cnt_inc;
					state_q   <= ST_COUNT;
				end
				ST_COUNT: begin
					if (!expired_q && gt) begin
						verdict_q <= VERDICT_RATE;
						first_q   <= !ent_q.noted;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.verdict          <= verdict_q;
						out_q.first_over_limit <= first_q;
						out_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A first-drop flag only ever rides on a rate-limit drop.
	`PBRL_ASSERT_NOW(a_first_needs_rate, out_valid && out_data.first_over_limit,
		out_data.verdict == VERDICT_RATE, "first_over_limit without a rate drop")

	// Only an invalid way is overwritten during the walk.
	`PBRL_ASSERT_NOW(a_insert_free_way, state_q == ST_MATCH && ram_wr_en,
		!rd_ent.valid, "insert over a valid way")

	// An accepted beat keeps the block busy in the next cycle.
	`PBRL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready,
		!in_ready, "second beat taken while one is in work")

endmodule

`default_nettype wire
